// File: design/ctb_pkg.sv
// Shared constants, control register type and prescaler table for the timer bank.
`default_nettype none

package ctb_pkg;

    // Defaults of the top-level parameters.
    localparam int NUM_TIMERS_DEF  = 4;
    localparam int COUNT_BITS_DEF  = 16;
    localparam int QUEUE_DEPTH_DEF = 2;

    // Fixed field widths of the stream and configuration ports.
    localparam int ELAPSED_W   = 10;
    localparam int RESIDUE_W   = 10;
    localparam int TICKS_W     = 11;
    localparam int OUT_COUNTS  = 4;
    localparam int OUT_COUNT_W = 16;
    localparam int IRQ_W       = 4;
    localparam int S_TDATA_W   = 16;
    localparam int M_TDATA_W   = 72;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int CTL_W       = 5;

    // Register map: reload values first, then control words.
    localparam int REG_SLOTS         = 4;
    localparam int CFG_RELOAD_BASE   = 0;
    localparam int CFG_CONTROL_BASE  = 4;

    // Control word, bit 4 down to bit 0.
    typedef struct packed {
        logic       enable;
        logic       irq_en;
        logic       cascade;
        logic [1:0] psel;
    } t_ctl;

    // Prescaler select to right-shift amount: divide by 1, 64, 256 or 1024.
    function automatic logic [3:0] f_prescale_shift(input logic [1:0] sel);
        logic [3:0] sh;
        unique case (sel)
            2'd0:    sh = 4'd0;
            2'd1:    sh = 4'd6;
            2'd2:    sh = 4'd8;
            default: sh = 4'd10;
        endcase
        return sh;
    endfunction

endpackage

`default_nettype wire

// File: design/ctb_front.sv
// Front end: accepts elapsed-cycle requests and marks which timers count cycles.
`default_nettype none

module ctb_front #(
    parameter int NUM_TIMERS = ctb_pkg::NUM_TIMERS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_s_tvalid,
    output logic                               o_s_tready,
    input  wire logic [ctb_pkg::ELAPSED_W-1:0] i_elapsed,
    input  wire ctb_pkg::t_ctl                 i_ctl [NUM_TIMERS],
    output logic                               o_q_valid,
    input  wire logic                          i_q_ready,
    // Queue entry: elapsed cycles in the low bits, source-timer mask above.
    output logic [ctb_pkg::ELAPSED_W+NUM_TIMERS-1:0] o_q_data
);

    localparam int ENTRY_W = ctb_pkg::ELAPSED_W + NUM_TIMERS;

    logic               r_valid;
    logic [ENTRY_W-1:0] r_entry;
    logic [NUM_TIMERS-1:0] w_src;

    // A timer counts cycles when enabled and not chained; timer 0 never chains.
    always_comb begin
        for (int i = 0; i < NUM_TIMERS; i++) begin
            w_src[i] = i_ctl[i].enable && ((i == 0) || !i_ctl[i].cascade);
        end
    end

    assign o_s_tready = !r_valid || i_q_ready;
    assign o_q_valid  = r_valid;
    assign o_q_data   = r_entry;

    // Holding stage in front of the queue.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_valid <= i_s_tvalid;
        end
        if (i_s_tvalid && o_s_tready) begin
            r_entry <= {w_src, i_elapsed};
        end
    end

endmodule

`default_nettype wire

// File: design/ctb_queue.sv
// Small first-in first-out queue between the front end and the sequencer.
`default_nettype none

module ctb_queue #(
    parameter int WIDTH = 14,
    parameter int DEPTH = ctb_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push_valid,
    output logic                  o_push_ready,
    input  wire logic [WIDTH-1:0] i_push_data,
    output logic                  o_pop_valid,
    input  wire logic             i_pop_ready,
    output logic [WIDTH-1:0]      o_pop_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic             w_push;
    logic             w_pop;

    assign o_push_ready = (r_count != CW'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_mem[r_rd_ptr];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Storage.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

`default_nettype wire

// File: design/ctb_back.sv
// Sequencer: advances each timer in turn, one overflow per cycle, with cascade ripple.
`default_nettype none

module ctb_back #(
    parameter int NUM_TIMERS = ctb_pkg::NUM_TIMERS_DEF,
    parameter int COUNT_BITS = ctb_pkg::COUNT_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_q_valid,
    output logic                                   o_q_ready,
    // Queue entry: elapsed cycles in the low bits, source-timer mask above.
    input  wire logic [ctb_pkg::ELAPSED_W+NUM_TIMERS-1:0] i_q_data,
    input  wire ctb_pkg::t_ctl                     i_ctl    [NUM_TIMERS],
    input  wire logic [COUNT_BITS-1:0]             i_reload [NUM_TIMERS],
    output logic                                   o_m_tvalid,
    input  wire logic                              i_m_tready,
    output logic [ctb_pkg::M_TDATA_W-1:0]          o_m_tdata
);

    localparam int TW = $clog2(NUM_TIMERS);
    localparam int VW = COUNT_BITS + ctb_pkg::TICKS_W;
    localparam int EW = ctb_pkg::ELAPSED_W;
    localparam int RW = ctb_pkg::RESIDUE_W;
    localparam int KW = ctb_pkg::TICKS_W;
    localparam int OW = ctb_pkg::OUT_COUNT_W;
    localparam logic [VW-1:0] WRAP = VW'(1) << COUNT_BITS;

    typedef enum logic [1:0] {
        S_IDLE,
        S_STEP,
        S_OVF,
        S_DONE
    } t_state;

    t_state                  r_state;
    logic [TW-1:0]           r_t;
    logic [EW-1:0]           r_cycles;
    logic [NUM_TIMERS-1:0]   r_src;
    logic [NUM_TIMERS-1:0]   r_irq;
    logic [VW-1:0]           r_val;
    logic [COUNT_BITS-1:0]   r_cnt [NUM_TIMERS];
    logic [RW-1:0]           r_res [NUM_TIMERS];
    logic                    r_m_valid;
    logic [ctb_pkg::M_TDATA_W-1:0] r_m_data;

    ctb_pkg::t_ctl           w_ctl;
    logic [3:0]              w_sh;
    logic [KW-1:0]           w_sum;
    logic [KW-1:0]           w_ticks;
    logic [KW-1:0]           w_mask;
    logic [RW-1:0]           w_res;
    logic [VW-1:0]           w_val;
    logic                    w_val_ovf;
    logic [VW-1:0]           w_wrap;
    logic                    w_wrap_ovf;
    logic                    w_last;
    logic                    w_carry;
    logic [COUNT_BITS-1:0]   n_rip_cnt [NUM_TIMERS];
    logic [NUM_TIMERS-1:0]   n_rip_irq;
    logic [ctb_pkg::M_TDATA_W-1:0] w_out;

    // Prescaler step for the current timer: whole ticks and the new residue.
    always_comb begin
        w_ctl     = i_ctl[r_t];
        w_sh      = ctb_pkg::f_prescale_shift(w_ctl.psel);
        w_sum     = KW'(r_res[r_t]) + KW'(r_cycles);
        w_ticks   = w_sum >> w_sh;
        w_mask    = (KW'(1) << w_sh) - 1'b1;
        w_res     = RW'(w_sum & w_mask);
        w_val     = VW'(r_cnt[r_t]) + VW'(w_ticks);
        w_val_ovf = (w_val[VW-1:COUNT_BITS] != '0);
        w_wrap    = r_val - WRAP + VW'(i_reload[r_t]);
        w_wrap_ovf = (w_wrap[VW-1:COUNT_BITS] != '0);
        w_last    = (r_t == TW'(NUM_TIMERS - 1));
    end

    // One overflow of the current timer: ripple into the chained timers after it,
    // its own irq bit, and its final count once reload plus excess fits.
    always_comb begin
        n_rip_cnt = r_cnt;
        n_rip_irq = '0;
        w_carry   = 1'b1;
        for (int j = 0; j < NUM_TIMERS; j++) begin
            if (j > int'(r_t)) begin
                if (w_carry && i_ctl[j].enable && i_ctl[j].cascade) begin
                    if (&r_cnt[j]) begin
                        n_rip_cnt[j] = i_reload[j];
                        n_rip_irq[j] = i_ctl[j].irq_en;
                    end else begin
                        n_rip_cnt[j] = r_cnt[j] + 1'b1;
                        w_carry      = 1'b0;
                    end
                end else begin
                    w_carry = 1'b0;
                end
            end
        end
        if (w_ctl.irq_en) begin
            n_rip_irq[r_t] = 1'b1;
        end
        if (!w_wrap_ovf) begin
            n_rip_cnt[r_t] = w_wrap[COUNT_BITS-1:0];
        end
    end

    // Result packing; timers that do not exist report zero.
    for (genvar k = 0; k < ctb_pkg::OUT_COUNTS; k++) begin : g_out
        if (k < NUM_TIMERS) begin : g_live
            assign w_out[k*OW +: OW] = OW'(r_cnt[k]);
            assign w_out[ctb_pkg::OUT_COUNTS*OW + k] = r_irq[k];
        end else begin : g_none
            assign w_out[k*OW +: OW] = '0;
            assign w_out[ctb_pkg::OUT_COUNTS*OW + k] = 1'b0;
        end
    end
    assign w_out[ctb_pkg::M_TDATA_W-1:ctb_pkg::OUT_COUNTS*OW+ctb_pkg::IRQ_W] = '0;

    assign o_q_ready  = (r_state == S_IDLE);
    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;

    // Sequencer, timer state and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_m_valid <= 1'b0;
            for (int i = 0; i < NUM_TIMERS; i++) begin
                r_cnt[i] <= '0;
                r_res[i] <= '0;
            end
        end else begin
            // A taken result empties the output register unless a new one loads it.
            if (r_m_valid && i_m_tready && (r_state != S_DONE)) begin
                r_m_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_cycles <= i_q_data[EW-1:0];
                        r_src    <= i_q_data[EW +: NUM_TIMERS];
                        r_irq    <= '0;
                        r_t      <= '0;
                        r_state  <= S_STEP;
                    end
                end
                S_STEP: begin
                    if (r_src[r_t] && w_val_ovf) begin
                        r_res[r_t] <= w_res;
                        r_val      <= w_val;
                        r_state    <= S_OVF;
                    end else begin
                        if (r_src[r_t]) begin
                            r_res[r_t] <= w_res;
                            r_cnt[r_t] <= w_val[COUNT_BITS-1:0];
                        end
                        if (w_last) begin
                            r_state <= S_DONE;
                        end else begin
                            r_t <= r_t + 1'b1;
                        end
                    end
                end
                S_OVF: begin
                    // One overflow: reload plus excess, irq, and one ripple.
                    r_cnt <= n_rip_cnt;
                    r_irq <= r_irq | n_rip_irq;
                    if (w_wrap_ovf) begin
                        r_val <= w_wrap;
                    end else begin
                        if (w_last) begin
                            r_state <= S_DONE;
                        end else begin
                            r_t     <= r_t + 1'b1;
                            r_state <= S_STEP;
                        end
                    end
                end
                S_DONE: begin
                    if (!r_m_valid || i_m_tready) begin
                        r_m_valid <= 1'b1;
                        r_m_data  <= w_out;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// File: design/cascaded_timer_bank.sv
// A request passes the front-end holding register and the queue into the sequencer, which
// steps through every timer plus one overflow step for every counter overflow of a
// cycle-counting timer (its cascade ripple included). The single sequencer takes one
// request at a time; a small queue lets new requests be taken while a result waits.
// Reset (synchronous, active low) clears all counters, residues, reload and control
// registers, the queue and the output register.
`default_nettype none

module cascaded_timer_bank #(
    parameter int NUM_TIMERS  = ctb_pkg::NUM_TIMERS_DEF,
    parameter int COUNT_BITS  = ctb_pkg::COUNT_BITS_DEF,
    parameter int QUEUE_DEPTH = ctb_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // Input stream.
    input  wire logic                           i_s_tvalid,
    output logic                                o_s_tready,
    // tdata: [9:0] elapsed_cycles, [15:10] zero.
    input  wire logic [ctb_pkg::S_TDATA_W-1:0]  i_s_tdata,
    // Result stream.
    output logic                                o_m_tvalid,
    input  wire logic                           i_m_tready,
    // tdata: [15:0] count_zero, [31:16] count_one, [47:32] count_two,
    // [63:48] count_three, [67:64] irq_raised, [71:68] zero.
    output logic [ctb_pkg::M_TDATA_W-1:0]       o_m_tdata,
    // Configuration write channel.
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [ctb_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [ctb_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int ENTRY_W = ctb_pkg::ELAPSED_W + NUM_TIMERS;

    logic [COUNT_BITS-1:0] r_reload [NUM_TIMERS];
    ctb_pkg::t_ctl         r_ctl    [NUM_TIMERS];

    logic               w_fq_valid;
    logic               w_fq_ready;
    logic [ENTRY_W-1:0] w_fq_data;
    logic               w_qb_valid;
    logic               w_qb_ready;
    logic [ENTRY_W-1:0] w_qb_data;

    assign o_cfg_ready = 1'b1;

    // Register file; writes to timers that do not exist are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_TIMERS; i++) begin
                r_reload[i] <= '0;
                r_ctl[i]    <= '0;
            end
        end else if (i_cfg_valid) begin
            for (int i = 0; i < NUM_TIMERS; i++) begin
                if (i < ctb_pkg::REG_SLOTS) begin
                    if (i_cfg_index ==
                        ctb_pkg::CFG_IDX_W'(ctb_pkg::CFG_RELOAD_BASE + i)) begin
                        r_reload[i] <= COUNT_BITS'(i_cfg_data);
                    end
                    if (i_cfg_index ==
                        ctb_pkg::CFG_IDX_W'(ctb_pkg::CFG_CONTROL_BASE + i)) begin
                        r_ctl[i] <= ctb_pkg::t_ctl'(i_cfg_data[ctb_pkg::CTL_W-1:0]);
                    end
                end
            end
        end
    end

    ctb_front #(
        .NUM_TIMERS (NUM_TIMERS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_elapsed  (i_s_tdata[ctb_pkg::ELAPSED_W-1:0]),
        .i_ctl      (r_ctl),
        .o_q_valid  (w_fq_valid),
        .i_q_ready  (w_fq_ready),
        .o_q_data   (w_fq_data)
    );

    ctb_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_fq_valid),
        .o_push_ready (w_fq_ready),
        .i_push_data  (w_fq_data),
        .o_pop_valid  (w_qb_valid),
        .i_pop_ready  (w_qb_ready),
        .o_pop_data   (w_qb_data)
    );

    ctb_back #(
        .NUM_TIMERS (NUM_TIMERS),
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (w_qb_valid),
        .o_q_ready  (w_qb_ready),
        .i_q_data   (w_qb_data),
        .i_ctl      (r_ctl),
        .i_reload   (r_reload),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

endmodule

`default_nettype wire

// File: design/ctb_checker.sv
// Port-level checks of the timer bank and the bind that attaches them.
`default_nettype none

module ctb_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_s_tvalid,
    input wire logic                          o_s_tready,
    input wire logic                          o_m_tvalid,
    input wire logic                          i_m_tready,
    input wire logic [ctb_pkg::M_TDATA_W-1:0] o_m_tdata
);

    logic [7:0] r_pending;

    // Requests taken but not yet answered.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= r_pending + 8'(i_s_tvalid && o_s_tready)
                                   - 8'(o_m_tvalid && i_m_tready);
        end
    end

    // A stalled result keeps its value.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result changed while stalled");

    // Reset empties the output register.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

    // Padding bits of a result are zero.
    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[ctb_pkg::M_TDATA_W-1:68] == '0))
        else $error("nonzero padding in result");

    // Every result answers a request taken earlier.
    a_no_extra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && i_m_tready |-> (r_pending != '0))
        else $error("result without a pending request");

endmodule

bind cascaded_timer_bank ctb_checker u_ctb_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

`default_nettype wire

// File: sim/cascaded_timer_bank_checker.sv
// Result checker for the cascaded timer bank: mirrors its registers, predicts and compares results.
`timescale 1ns / 100ps

module cascaded_timer_bank_checker (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_s_tvalid,
    input  wire logic                           i_s_tready,
    // tdata: [9:0] elapsed_cycles, [15:10] zero.
    input  wire logic [ctb_pkg::S_TDATA_W-1:0]  i_s_tdata,
    input  wire logic                           i_m_tvalid,
    input  wire logic                           i_m_tready,
    // tdata: [15:0] count_zero, [31:16] count_one, [47:32] count_two,
    // [63:48] count_three, [67:64] irq_raised, [71:68] zero.
    input  wire logic [ctb_pkg::M_TDATA_W-1:0]  i_m_tdata,
    input  wire logic                           i_cfg_valid,
    input  wire logic                           i_cfg_ready,
    input  wire logic [ctb_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [ctb_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                                  o_mismatches,
    output int                                  o_outstanding
);

    localparam int TIMERS       = ctb_pkg::NUM_TIMERS_DEF;
    localparam int REPORT_LIMIT = 10;
    localparam int SNAP_W       = ctb_pkg::IRQ_W + ctb_pkg::OUT_COUNTS * ctb_pkg::OUT_COUNT_W;

    // One result: the four counts in the low bits, the raised IRQ bits above them.
    typedef struct packed {
        logic [ctb_pkg::IRQ_W-1:0]                                irq;
        logic [ctb_pkg::OUT_COUNTS-1:0][ctb_pkg::OUT_COUNT_W-1:0] counts;
    } t_timer_snapshot;

    logic [ctb_pkg::OUT_COUNT_W-1:0] count_mirror   [TIMERS];
    logic [ctb_pkg::RESIDUE_W-1:0]   residue_mirror [TIMERS];
    logic [ctb_pkg::OUT_COUNT_W-1:0] reload_mirror  [TIMERS];
    ctb_pkg::t_ctl                   control_mirror [TIMERS];
    t_timer_snapshot                 pending_snapshots [$];
    int                              mismatch_count = 0;
    int                              pending_results = 0;

    assign o_mismatches  = mismatch_count;
    assign o_outstanding = pending_results;

    // Right shift that a prescaler select stands for.
    function automatic int divider_shift(input logic [1:0] sel);
        int sh;
        case (sel)
            2'd0:    sh = 0;
            2'd1:    sh = 6;
            2'd2:    sh = 8;
            default: sh = 10;
        endcase
        return sh;
    endfunction

    // One overflow of timer src carries into the cascaded timers after it.
    task automatic ripple_up(input int src, inout logic [ctb_pkg::IRQ_W-1:0] irq);
        int  t;
        bit  carry;
        carry = 1'b1;
        for (t = src + 1; t < TIMERS; t++) begin
            if (carry) begin
                if (!(control_mirror[t].enable && control_mirror[t].cascade)) begin
                    carry = 1'b0;
                end else if (count_mirror[t] == '1) begin
                    count_mirror[t] = reload_mirror[t];
                    if (control_mirror[t].irq_en) begin
                        irq[t] = 1'b1;
                    end
                end else begin
                    count_mirror[t] = count_mirror[t] + 1'b1;
                    carry = 1'b0;
                end
            end
        end
    endtask

    // Advance every cycle-counting timer by the elapsed cycles of one request.
    task automatic advance_timers(input logic [ctb_pkg::ELAPSED_W-1:0] elapsed,
                                  output t_timer_snapshot snap);
        int                        t;
        int                        shift;
        logic [31:0]               sum;
        logic [31:0]               ticks;
        logic [31:0]               kept;
        logic [31:0]               total;
        logic [ctb_pkg::IRQ_W-1:0] irq;
        irq = '0;
        for (t = 0; t < TIMERS; t++) begin
            if (control_mirror[t].enable && (t == 0 || !control_mirror[t].cascade)) begin
                shift = divider_shift(control_mirror[t].psel);
                sum   = 32'(residue_mirror[t]) + 32'(elapsed);
                ticks = sum >> shift;
                kept  = sum & ((32'd1 << shift) - 32'd1);
                residue_mirror[t] = kept[ctb_pkg::RESIDUE_W-1:0];
                if (ticks != 32'd0) begin
                    total = 32'(count_mirror[t]) + ticks;
                    // A reload close to the top can overflow again and again.
                    while (total > 32'h0000_FFFF) begin
                        total = 32'(reload_mirror[t]) + (total - 32'h0001_0000);
                        if (control_mirror[t].irq_en) begin
                            irq[t] = 1'b1;
                        end
                        ripple_up(t, irq);
                    end
                    count_mirror[t] = total[ctb_pkg::OUT_COUNT_W-1:0];
                end
            end
        end
        snap.irq = irq;
        for (t = 0; t < ctb_pkg::OUT_COUNTS; t++) begin
            snap.counts[t] = (t < TIMERS) ? count_mirror[t] : '0;
        end
    endtask

    task automatic flag_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
            $display("%0t ns: %s", $time, msg);
        end
    endtask

    // Follow register writes, requests and results at each rising edge.
    always @(posedge i_clk) begin : watch_channels
        t_timer_snapshot predicted;
        t_timer_snapshot seen;
        int              t;
        if (!i_rst_n) begin
            for (t = 0; t < TIMERS; t++) begin
                count_mirror[t]   = '0;
                residue_mirror[t] = '0;
                reload_mirror[t]  = '0;
                control_mirror[t] = '0;
            end
            pending_snapshots.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index < ctb_pkg::CFG_CONTROL_BASE) begin
                    reload_mirror[i_cfg_index - ctb_pkg::CFG_RELOAD_BASE] = i_cfg_data;
                end else begin
                    control_mirror[i_cfg_index - ctb_pkg::CFG_CONTROL_BASE] =
                        i_cfg_data[ctb_pkg::CTL_W-1:0];
                end
            end

            if (i_m_tvalid && i_m_tready) begin
                seen = i_m_tdata[SNAP_W-1:0];
                if (pending_snapshots.size() == 0) begin
                    flag_mismatch($sformatf("result with no pending request: %h", seen));
                end else begin
                    predicted = pending_snapshots.pop_front();
                    for (t = 0; t < ctb_pkg::OUT_COUNTS; t++) begin
                        if (seen.counts[t] !== predicted.counts[t]) begin
                            flag_mismatch($sformatf("count_%0d mismatch: expected %h, actual %h",
                                                    t, predicted.counts[t], seen.counts[t]));
                        end
                    end
                    if (seen.irq !== predicted.irq) begin
                        flag_mismatch($sformatf("irq_raised mismatch: expected %b, actual %b",
                                                predicted.irq, seen.irq));
                    end
                end
            end

            // Each accepted request yields exactly one result.
            if (i_s_tvalid && i_s_tready) begin
                advance_timers(i_s_tdata[ctb_pkg::ELAPSED_W-1:0], predicted);
                pending_snapshots.push_back(predicted);
            end
        end
        pending_results = pending_snapshots.size();
    end

endmodule

// File: sim/cascaded_timer_bank_test.sv
// Top-level testbench for the cascaded timer bank: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module cascaded_timer_bank_test;

    localparam int          RESET_CYCLES  = 7;
    localparam int          TOTAL_ITEMS   = 1570;
    localparam int          QUIET_AFTER   = 1420;
    localparam int          SETTLE_CYCLES = 16;
    localparam int          PUMP_ITEMS    = 100;
    localparam int          LIMIT_NS      = 100_000_000;
    localparam logic [15:0] RELOAD_HOT    = 16'hFFC0;

    typedef enum int {
        PHASE_PUMP,
        PHASE_CHAIN,
        PHASE_MIXED
    } t_phase_kind;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_s_tvalid;
    logic                            o_s_tready;
    logic [ctb_pkg::S_TDATA_W-1:0]   i_s_tdata;
    logic                            o_m_tvalid;
    logic                            i_m_tready;
    logic [ctb_pkg::M_TDATA_W-1:0]   o_m_tdata;
    logic                            i_cfg_valid;
    logic                            o_cfg_ready;
    logic [ctb_pkg::CFG_IDX_W-1:0]   i_cfg_index;
    logic [ctb_pkg::CFG_DATA_W-1:0]  i_cfg_data;
    int                              mismatches;
    int                              outstanding;

    logic [ctb_pkg::OUT_COUNT_W-1:0] reload_plan  [4];
    ctb_pkg::t_ctl                   control_plan [4];
    bit                              idle_on = 1'b0;
    bit                              quiet   = 1'b0;
    bit                              hot     = 1'b0;
    int                              items_sent = 0;

    cascaded_timer_bank DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    cascaded_timer_bank_checker u_timer_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (i_s_tvalid),
        .i_s_tready    (o_s_tready),
        .i_s_tdata     (i_s_tdata),
        .i_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .i_m_tdata     (o_m_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Stop a hung run.
    initial begin : watchdog
        #(LIMIT_NS);
        $display("Regression FAIL");
        $finish;
    end

    // Result side: ready runs and stall bursts, always ready near the end.
    initial begin : result_sink
        int len;
        i_m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (idle_on && !quiet && $urandom_range(2) == 0) begin
                len = $urandom_range(1, 5);
                i_m_tready <= 1'b0;
            end else begin
                len = $urandom_range(1, 12);
                i_m_tready <= 1'b1;
            end
            repeat (len - 1) @(negedge i_clk);
        end
    end

    // Stop sending and let every pending request drain.
    task automatic wait_for_idle();
        i_s_tvalid <= 1'b0;
        while (outstanding != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_register(input logic [ctb_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [ctb_pkg::CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
    endtask

    // Write all eight registers from the plan, starting at a random index.
    task automatic program_plan();
        int                   k;
        int                   first;
        int                   idx;
        logic [10:0]          pad;
        first = $urandom_range(7);
        wait_for_idle();
        for (k = 0; k < 2 * ctb_pkg::REG_SLOTS; k++) begin
            idx = (first + k) % (2 * ctb_pkg::REG_SLOTS);
            pad = 11'($urandom_range(2047));
            if (idx < ctb_pkg::CFG_CONTROL_BASE) begin
                write_register(idx[ctb_pkg::CFG_IDX_W-1:0],
                               reload_plan[idx - ctb_pkg::CFG_RELOAD_BASE]);
            end else begin
                write_register(idx[ctb_pkg::CFG_IDX_W-1:0],
                               {pad, control_plan[idx - ctb_pkg::CFG_CONTROL_BASE]});
            end
        end
        i_cfg_valid <= 1'b0;
        hot = 1'b0;
        for (k = 0; k < 4; k++) begin
            if (reload_plan[k] >= RELOAD_HOT) begin
                hot = 1'b1;
            end
        end
    endtask

    task automatic load_setting(input logic [15:0] r0, r1, r2, r3,
                                input logic [4:0] c0, c1, c2, c3);
        reload_plan[0]  = r0;
        reload_plan[1]  = r1;
        reload_plan[2]  = r2;
        reload_plan[3]  = r3;
        control_plan[0] = c0;
        control_plan[1] = c1;
        control_plan[2] = c2;
        control_plan[3] = c3;
        program_plan();
    endtask

    // Send one request; a random gap may come first.
    task automatic send_elapsed(input logic [ctb_pkg::ELAPSED_W-1:0] cycles);
        int gap;
        if (items_sent >= QUIET_AFTER) begin
            quiet = 1'b1;
        end
        if (idle_on && !quiet && $urandom_range(3) == 0) begin
            gap = $urandom_range(1, 5);
            i_s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {{(ctb_pkg::S_TDATA_W - ctb_pkg::ELAPSED_W){1'b0}}, cycles};
        do @(posedge i_clk); while (!o_s_tready);
        @(negedge i_clk);
        items_sent++;
    endtask

    // Reloads near the top overflow on almost every tick, so keep batches short then.
    function automatic logic [ctb_pkg::ELAPSED_W-1:0] pick_elapsed(input t_phase_kind kind);
        logic [ctb_pkg::ELAPSED_W-1:0] cyc;
        if (hot && $urandom_range(19) != 0) begin
            cyc = ctb_pkg::ELAPSED_W'($urandom_range(63));
        end else if (kind == PHASE_PUMP) begin
            cyc = ctb_pkg::ELAPSED_W'($urandom_range(512, 1023));
        end else begin
            case ($urandom_range(7))
                0:       cyc = '0;
                1:       cyc = '1;
                default: cyc = ctb_pkg::ELAPSED_W'($urandom_range(1023));
            endcase
        end
        return cyc;
    endfunction

    function automatic logic [15:0] pick_reload();
        logic [15:0] value;
        case ($urandom_range(7))
            0:       value = 16'h0000;
            1:       value = 16'hFFFF;
            2:       value = RELOAD_HOT + 16'($urandom_range(63));
            default: value = 16'($urandom_range(16'hFFFF));
        endcase
        return value;
    endfunction

    initial begin : stimulus
        t_phase_kind kind;
        int          phase_len;
        int          n;
        int          t;
        logic [4:0]  ctl_bits;
        i_rst_n     = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Everything disabled after reset: counts must stay at zero.
        send_elapsed(10'd0);
        send_elapsed(10'd1023);
        send_elapsed(10'd1);

        // All four prescalers; the cascade bit of timer 0 must be ignored.
        load_setting(16'h0000, 16'hFFFF, 16'h8000, 16'h0001,
                     5'b11100, 5'b11001, 5'b10010, 5'b11011);
        send_elapsed(10'd1023);
        send_elapsed(10'd1023);
        send_elapsed(10'd1023);
        send_elapsed(10'd63);
        send_elapsed(10'd64);
        send_elapsed(10'd255);
        send_elapsed(10'd1);
        send_elapsed(10'd0);
        send_elapsed(10'd1023);
        send_elapsed(10'd512);

        // Cascade chain cut by a disabled timer.
        load_setting(16'hFFFE, 16'h0000, 16'hFFFF, 16'h7FFF,
                     5'b10000, 5'b11111, 5'b01111, 5'b11100);
        send_elapsed(10'd1023);
        send_elapsed(10'd0);
        send_elapsed(10'd1023);
        send_elapsed(10'd1);

        // Cascade chain cut by a timer that counts cycles itself.
        load_setting(16'hFFFF, 16'hFFF0, 16'h0100, 16'hFFFF,
                     5'b11000, 5'b11100, 5'b11001, 5'b11111);
        send_elapsed(10'd1023);
        send_elapsed(10'd512);
        send_elapsed(10'd0);
        send_elapsed(10'd1023);

        // Random phases: pumps bring counters near the top, chains then ripple through them.
        kind = PHASE_PUMP;
        while (items_sent < TOTAL_ITEMS) begin
            case (kind)
                PHASE_PUMP: begin
                    for (t = 0; t < 4; t++) begin
                        reload_plan[t]         = 16'hFF00 + 16'($urandom_range(191));
                        control_plan[t]        = '0;
                        control_plan[t].enable = 1'b1;
                        control_plan[t].irq_en = 1'($urandom_range(1));
                    end
                end
                PHASE_CHAIN: begin
                    reload_plan[0]          = pick_reload();
                    control_plan[0].enable  = 1'b1;
                    control_plan[0].irq_en  = 1'($urandom_range(1));
                    control_plan[0].cascade = 1'($urandom_range(1));
                    control_plan[0].psel    = ($urandom_range(3) == 0) ? 2'd1 : 2'd0;
                    for (t = 1; t < 4; t++) begin
                        reload_plan[t]          = pick_reload();
                        ctl_bits                = 5'($urandom_range(31));
                        control_plan[t]         = ctl_bits;
                        control_plan[t].cascade = 1'b1;
                        control_plan[t].enable  = ($urandom_range(3) != 0);
                    end
                end
                default: begin
                    for (t = 0; t < 4; t++) begin
                        reload_plan[t] = pick_reload();
                        case ($urandom_range(5))
                            0:       ctl_bits = 5'b00000;
                            1:       ctl_bits = 5'b11111;
                            default: ctl_bits = 5'($urandom_range(31));
                        endcase
                        control_plan[t] = ctl_bits;
                    end
                end
            endcase
            program_plan();
            idle_on   = ($urandom_range(3) != 0);
            phase_len = (kind == PHASE_PUMP) ? PUMP_ITEMS : $urandom_range(30, 90);
            for (n = 0; n < phase_len && items_sent < TOTAL_ITEMS; n++) begin
                send_elapsed(pick_elapsed(kind));
            end
            case ($urandom_range(3))
                0:       kind = PHASE_PUMP;
                1:       kind = PHASE_CHAIN;
                default: kind = PHASE_MIXED;
            endcase
        end

        quiet = 1'b1;
        wait_for_idle();
        if (mismatches == 0 && outstanding == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
